[hw/rtl/cscr_pkg.sv]
// shared constants for the clipped sample cubic repair block
`timescale 1ns / 1ps

package cscr_pkg;

    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_MAX_GAP     = 32;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UPPER = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOWER = 2'd1;

endpackage

[hw/rtl/cscr_div.sv]
// iterative signed floor divider, one quotient bit per cycle
`timescale 1ns / 1ps

module cscr_div #(
    parameter int NW  = 51,
    parameter int DVW = 18
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [NW-1:0] dividend,
    input  logic [DVW-1:0]       divisor,
    output logic                 done,
    output logic signed [NW:0]   quotient
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] mag_reg;
    logic [DVW:0]  rem_reg;
    logic [DVW-1:0] div_reg;
    logic          neg_reg;
    logic          done_reg;
    logic signed [NW:0] quo_reg;

    logic [DVW:0]  rem_sh;
    logic          ge;
    logic [DVW:0]  rem_next;
    logic [NW-1:0] mag_next;
    logic [NW:0]   mag_ext;

    assign rem_sh   = {rem_reg[DVW-1:0], mag_reg[NW-1]};
    assign ge       = rem_sh >= {1'b0, div_reg};
    assign rem_next = ge ? rem_sh - {1'b0, div_reg} : rem_sh;
    assign mag_next = {mag_reg[NW-2:0], ge};
    assign mag_ext  = {1'b0, mag_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                neg_reg  <= dividend[NW-1];
                mag_reg  <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
                rem_reg  <= '0;
                div_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                mag_reg <= mag_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    // floor: round negative quotients down when inexact
                    if (neg_reg) begin
                        quo_reg <= $signed(-mag_ext) - $signed({{NW{1'b0}}, (rem_next != '0)});
                    end else begin
                        quo_reg <= $signed(mag_ext);
                    end
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !start |-> rem_reg < {1'b0, div_reg})
        else $error("divider remainder out of range");

endmodule

[hw/rtl/clipped_sample_cubic_repair.sv]
// clipped sample repair by cubic hermite interpolation over buffered runs
// a pass-through sample is held in s_reg, then registered in the output register; no new sample is
//   taken until it is emitted; a flushed raw run emits each buffered sample via ST_FL_RD and ST_FL_EM first
// closing a run of L samples: ST_H_INIT forms d squared and d cubed, then per repaired sample 10 multiply
//   steps on the shared multiplier, a divider start, the serial divide and an emit
// reset (synchronous): control state and cutoffs return to their defaults; run buffer not cleared
`timescale 1ns / 1ps

module clipped_sample_cubic_repair
    import cscr_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int MAX_GAP     = DEF_MAX_GAP
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]           cfg_index,
    input  logic [SAMPLE_BITS-1:0]            cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,   // sample
    input  logic                              s_tlast,   // frame_last
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,   // value
    output logic                              m_tlast,   // last_of_run
    output logic [1:0]                        m_tuser    // {frame_end, repaired}
);

    localparam int S   = SAMPLE_BITS;
    localparam int TW  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DW  = $clog2(MAX_GAP + 2);          // span d = L+1
    localparam int LW  = $clog2(MAX_GAP + 1);          // run length
    localparam int GA  = (MAX_GAP > 1) ? $clog2(MAX_GAP) : 1;
    localparam int AW  = S + 2 * DW + 3;               // wide multiplier operand
    localparam int BW  = 3 * DW + 2;                   // narrow multiplier operand
    localparam int PW  = AW + BW;                      // product and numerator
    localparam int DVW = 3 * DW;                       // d cubed
    localparam logic signed [PW:0] SAT_HI = (PW+1)'((64'sd1 <<< (S - 1)) - 64'sd1);
    localparam logic signed [PW:0] SAT_LO = -SAT_HI - (PW+1)'(1);

    typedef enum logic [1:0] {PH_IDLE, PH_RUN, PH_HOLD, PH_RAW} phase_t;
    typedef enum logic [3:0] {
        ST_IN, ST_FL_RD, ST_FL_EM, ST_EMS, ST_H_INIT, ST_H_MUL,
        ST_H_DST, ST_H_DIV, ST_H_EM, ST_H_END
    } state_t;

    state_t  st_reg;
    phase_t  phase_reg;
    logic [1:0] seen_reg;

    logic signed [S-1:0] upper_reg, lower_reg;
    logic signed [S-1:0] bp_reg, pr_reg, held_reg, s_reg, lastval_reg;
    logic        last_reg, clip_reg;
    logic [LW-1:0] len_reg, idx_reg;
    logic [DW-1:0] d_reg, k_reg;
    logic [2*DW-1:0] d2_reg;
    logic [DVW-1:0]  d3_reg;
    logic [3:0]      step_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [AW-1:0] w_reg;
    logic signed [BW-1:0] tmp_reg;

    // run buffer
    logic [S-1:0] gap_mem [MAX_GAP];
    logic [S-1:0] rd_reg;
    logic         mem_we;
    logic [GA-1:0] mem_wa;

    // output register
    logic         m_valid_reg;
    logic [S-1:0] m_val_reg;
    logic         m_rep_reg, m_lor_reg, m_fe_reg;

    logic signed [S-1:0] s_in;
    logic        clip_in, accept, newrun;

    assign s_in    = $signed(s_tdata[S-1:0]);
    assign clip_in = (s_in > upper_reg) || (s_in < lower_reg);
    assign accept  = s_tvalid && s_tready;
    // no transfer is taken while reset is held
    assign s_tready  = aresetn && (st_reg == ST_IN);
    assign cfg_ready = aresetn;
    assign newrun  = clip_reg && !last_reg;

    // shared multiplier
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [S:0]    m1, m2, de;
    logic [DW-1:0]        dk;
    logic signed [DW+1:0] tkd;

    assign m1  = (S+1)'(pr_reg) - (S+1)'(bp_reg);
    assign m2  = (S+1)'(s_reg) - (S+1)'(held_reg);
    assign de  = (S+1)'(held_reg) - (S+1)'(pr_reg);
    assign dk  = d_reg - k_reg;
    assign tkd = $signed({1'b0, k_reg, 1'b0}) - $signed({2'b0, d_reg});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (st_reg == ST_H_INIT) begin
            mul_a = (step_reg == 4'd0) ? $signed({{(AW-DW){1'b0}}, d_reg})
                                       : $signed({{(AW-2*DW){1'b0}}, d2_reg});
            mul_b = $signed({{(BW-DW){1'b0}}, d_reg});
        end else if (st_reg == ST_H_MUL) begin
            unique case (step_reg)
                4'd0: begin mul_a = AW'(m1); mul_b = $signed({{(BW-DW){1'b0}}, dk}); end
                4'd1: begin mul_a = AW'(m2); mul_b = $signed({{(BW-DW){1'b0}}, k_reg}); end
                4'd2: begin mul_a = acc_reg[AW-1:0]; mul_b = $signed({{(BW-DW){1'b0}}, d_reg}); end
                4'd3: begin mul_a = AW'(de); mul_b = BW'(tkd); end
                4'd4: begin
                    mul_a = $signed({{(AW-DW){1'b0}}, k_reg});
                    mul_b = $signed({{(BW-DW){1'b0}}, dk});
                end
                4'd5: begin mul_a = w_reg; mul_b = tmp_reg; end
                4'd6: begin
                    mul_a = $signed({{(AW-2*DW){1'b0}}, d2_reg});
                    mul_b = $signed({{(BW-DW){1'b0}}, dk});
                end
                4'd7: begin mul_a = AW'(pr_reg); mul_b = tmp_reg; end
                4'd8: begin
                    mul_a = $signed({{(AW-2*DW){1'b0}}, d2_reg});
                    mul_b = $signed({{(BW-DW){1'b0}}, k_reg});
                end
                4'd9: begin mul_a = AW'(held_reg); mul_b = tmp_reg; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    // divider
    logic                 div_done;
    logic signed [PW:0]   div_q;
    logic signed [S-1:0]  hval;

    cscr_div #(.NW(PW), .DVW(DVW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (st_reg == ST_H_DST),
        .dividend (acc_reg),
        .divisor  (d3_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // the quotient is held by the divider until the next division completes
    always_comb begin
        priority if (div_q > SAT_HI) hval = SAT_HI[S-1:0];
        else if (div_q < SAT_LO)     hval = SAT_LO[S-1:0];
        else                         hval = div_q[S-1:0];
    end

    // result selection for the current sequencer step
    logic         em_go, em_rep, em_lor, em_fe, em_fire;
    logic [S-1:0] em_val;

    always_comb begin
        em_go  = 1'b0;
        em_val = s_reg;
        em_rep = 1'b0;
        em_lor = 1'b0;
        em_fe  = 1'b0;
        unique case (st_reg)
            ST_FL_EM: begin em_go = 1'b1; em_val = rd_reg; end
            ST_EMS:   begin em_go = 1'b1; em_lor = 1'b1; em_fe = last_reg; end
            ST_H_EM:  begin em_go = 1'b1; em_val = hval; em_rep = 1'b1; end
            ST_H_END: begin em_go = 1'b1; em_val = held_reg; em_lor = newrun; end
            default:  em_go = 1'b0;
        endcase
    end

    assign em_fire = em_go && (!m_valid_reg || m_tready);

    // buffer write on transfer when a run grows or starts
    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        if (accept && clip_in && !s_tlast) begin
            unique case (phase_reg)
                PH_IDLE: mem_we = (seen_reg == 2'd2);
                PH_RUN: begin
                    mem_we = (len_reg < LW'(MAX_GAP));
                    mem_wa = len_reg[GA-1:0];
                end
                PH_HOLD: mem_we = 1'b1;
                PH_RAW:  mem_we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            gap_mem[mem_wa] <= s_in;
        end
        rd_reg <= gap_mem[idx_reg[GA-1:0]];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IN;
            phase_reg   <= PH_IDLE;
            seen_reg    <= 2'd0;
            len_reg     <= '0;
            bp_reg      <= '0;
            pr_reg      <= '0;
            held_reg    <= '0;
            upper_reg   <= SAT_HI[S-1:0];
            lower_reg   <= SAT_LO[S-1:0];
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_UPPER: upper_reg <= cfg_data;
                    CFG_LOWER: lower_reg <= cfg_data;
                    default:   ;
                endcase
            end

            if (em_fire) begin
                m_valid_reg <= 1'b1;
                m_val_reg   <= em_val;
                m_rep_reg   <= em_rep;
                m_lor_reg   <= em_lor;
                m_fe_reg    <= em_fe;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (st_reg)
                ST_IN: begin
                    if (accept) begin
                        s_reg    <= s_in;
                        last_reg <= s_tlast;
                        clip_reg <= clip_in;
                        idx_reg  <= '0;
                        if (seen_reg != 2'd2) seen_reg <= seen_reg + 2'd1;
                        unique case (phase_reg)
                            PH_IDLE: begin
                                if (clip_in && seen_reg == 2'd2 && !s_tlast) begin
                                    len_reg   <= LW'(1);
                                    phase_reg <= PH_RUN;
                                end else begin
                                    st_reg <= ST_EMS;
                                    if (clip_in) phase_reg <= PH_RAW;
                                end
                            end
                            PH_RUN: begin
                                if (s_tlast) begin
                                    st_reg <= ST_FL_RD;
                                end else if (clip_in) begin
                                    if (len_reg < LW'(MAX_GAP)) begin
                                        len_reg <= len_reg + 1'b1;
                                    end else begin
                                        st_reg    <= ST_FL_RD;
                                        phase_reg <= PH_RAW;
                                    end
                                end else begin
                                    held_reg  <= s_in;
                                    phase_reg <= PH_HOLD;
                                end
                            end
                            PH_HOLD: begin
                                d_reg    <= DW'(len_reg) + DW'(1);
                                step_reg <= 4'd0;
                                st_reg   <= ST_H_INIT;
                            end
                            PH_RAW: begin
                                st_reg <= ST_EMS;
                                if (!clip_in) phase_reg <= PH_IDLE;
                            end
                        endcase
                    end
                end
                ST_FL_RD: st_reg <= ST_FL_EM;
                ST_FL_EM: begin
                    if (em_fire) begin
                        bp_reg  <= pr_reg;
                        pr_reg  <= rd_reg;
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg + 1'b1 == len_reg) begin
                            len_reg <= '0;
                            st_reg  <= ST_EMS;
                        end else begin
                            st_reg <= ST_FL_RD;
                        end
                    end
                end
                ST_EMS: begin
                    if (em_fire) begin
                        bp_reg <= pr_reg;
                        pr_reg <= s_reg;
                        st_reg <= ST_IN;
                        if (last_reg) begin
                            phase_reg <= PH_IDLE;
                            len_reg   <= '0;
                            seen_reg  <= 2'd0;
                        end
                    end
                end
                ST_H_INIT: begin
                    if (step_reg == 4'd0) begin
                        d2_reg   <= prod[2*DW-1:0];
                        step_reg <= 4'd1;
                    end else begin
                        d3_reg   <= prod[DVW-1:0];
                        step_reg <= 4'd0;
                        k_reg    <= DW'(1);
                        st_reg   <= ST_H_MUL;
                    end
                end
                ST_H_MUL: begin
                    step_reg <= step_reg + 4'd1;
                    unique case (step_reg)
                        4'd0:    acc_reg <= prod;
                        4'd1:    acc_reg <= acc_reg - prod;
                        4'd2:    acc_reg <= prod;
                        4'd3:    w_reg   <= acc_reg[AW-1:0] + prod[AW-1:0];
                        4'd4:    tmp_reg <= prod[BW-1:0];
                        4'd5:    acc_reg <= prod;
                        4'd6:    tmp_reg <= prod[BW-1:0];
                        4'd7:    acc_reg <= acc_reg + prod;
                        4'd8:    tmp_reg <= prod[BW-1:0];
                        4'd9: begin
                            // round half up before the floor division
                            acc_reg <= acc_reg + prod
                                     + $signed({{(PW-DVW){1'b0}}, d3_reg >> 1});
                            st_reg  <= ST_H_DST;
                        end
                        default: acc_reg <= acc_reg;
                    endcase
                end
                ST_H_DST: st_reg <= ST_H_DIV;
                ST_H_DIV: if (div_done) st_reg <= ST_H_EM;
                ST_H_EM: begin
                    if (em_fire) begin
                        lastval_reg <= hval;
                        if (k_reg == DW'(len_reg)) begin
                            st_reg <= ST_H_END;
                        end else begin
                            k_reg    <= k_reg + 1'b1;
                            step_reg <= 4'd0;
                            st_reg   <= ST_H_MUL;
                        end
                    end
                end
                ST_H_END: begin
                    if (em_fire) begin
                        if (newrun) begin
                            bp_reg    <= lastval_reg;
                            pr_reg    <= held_reg;
                            len_reg   <= LW'(1);
                            phase_reg <= PH_RUN;
                            st_reg    <= ST_IN;
                        end else begin
                            // current sample follows and shifts the end sample into history
                            pr_reg    <= held_reg;
                            len_reg   <= '0;
                            phase_reg <= clip_reg ? PH_RAW : PH_IDLE;
                            st_reg    <= ST_EMS;
                        end
                    end
                end
                default: st_reg <= ST_IN;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TW'(m_val_reg);
    assign m_tlast  = m_lor_reg;
    assign m_tuser  = {m_fe_reg, m_rep_reg};

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(MAX_GAP))
        else $error("run length beyond buffer");

    a_rep_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_rep_reg |-> !m_lor_reg && !m_fe_reg)
        else $error("repaired sample closes an item");

    a_hold_has_run: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HOLD && st_reg == ST_IN |-> len_reg != '0)
        else $error("end sample held without buffered run");

endmodule
